FILE: sv/c8enc_pkg.sv
// Types, codes and the instruction format table shared by the encoder files.
package c8enc_pkg;

  // Field widths of one instruction word and one result word.
  localparam int unsigned MnW    = 5;
  localparam int unsigned CntW   = 2;
  localparam int unsigned KindW  = 4;
  localparam int unsigned ValW   = 12;
  localparam int unsigned OpW    = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned NumOps = 3;
  localparam int unsigned NumFmt = 46;
  localparam int unsigned FmtIdxW = $clog2(NumFmt);

  typedef logic [MnW-1:0]   mnemonic_t;
  typedef logic [CntW-1:0]  count_t;
  typedef logic [KindW-1:0] kind_t;
  typedef logic [ValW-1:0]  value_t;
  typedef logic [OpW-1:0]   opcode_t;

  // Mnemonic codes.
  localparam mnemonic_t MN_CLS  = 5'd0;
  localparam mnemonic_t MN_RET  = 5'd1;
  localparam mnemonic_t MN_JP   = 5'd2;
  localparam mnemonic_t MN_CALL = 5'd3;
  localparam mnemonic_t MN_SE   = 5'd4;
  localparam mnemonic_t MN_SNE  = 5'd5;
  localparam mnemonic_t MN_LD   = 5'd6;
  localparam mnemonic_t MN_ADD  = 5'd7;
  localparam mnemonic_t MN_OR   = 5'd8;
  localparam mnemonic_t MN_AND  = 5'd9;
  localparam mnemonic_t MN_SUB  = 5'd10;
  localparam mnemonic_t MN_SHR  = 5'd11;
  localparam mnemonic_t MN_SUBN = 5'd12;
  localparam mnemonic_t MN_SHL  = 5'd13;
  localparam mnemonic_t MN_RND  = 5'd14;
  localparam mnemonic_t MN_DRW  = 5'd15;
  localparam mnemonic_t MN_SKP  = 5'd16;
  localparam mnemonic_t MN_SKNP = 5'd17;
  localparam mnemonic_t MN_XOR  = 5'd18;
  localparam mnemonic_t MN_SCD  = 5'd19;
  localparam mnemonic_t MN_SCR  = 5'd20;
  localparam mnemonic_t MN_SCL  = 5'd21;
  localparam mnemonic_t MN_EXIT = 5'd22;
  localparam mnemonic_t MN_LOW  = 5'd23;
  localparam mnemonic_t MN_HIGH = 5'd24;
  localparam mnemonic_t MN_JPV0 = 5'd25;

  // Operand kind codes.
  localparam kind_t K_NONE = 4'd0;
  localparam kind_t K_V    = 4'd1;
  localparam kind_t K_I4   = 4'd2;
  localparam kind_t K_I8   = 4'd3;
  localparam kind_t K_I12  = 4'd4;
  localparam kind_t K_DT   = 4'd5;
  localparam kind_t K_ST   = 4'd6;
  localparam kind_t K_I    = 4'd7;
  localparam kind_t K_IP   = 4'd8;
  localparam kind_t K_K    = 4'd9;
  localparam kind_t K_F    = 4'd10;
  localparam kind_t K_B    = 4'd11;
  localparam kind_t K_HF   = 4'd12;
  localparam kind_t K_R    = 4'd13;

  // Result status.
  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NO_FORMAT = 2'd2
  } status_e;

  // Nibble position at which an operand is placed, or not placed at all.
  typedef enum logic [1:0] {
    P0 = 2'd0,
    P4 = 2'd1,
    P8 = 2'd2,
    PN = 2'd3
  } pos_e;

  typedef struct packed {
    mnemonic_t mn;
    count_t    cnt;
    opcode_t   base;
    kind_t     kind0;
    kind_t     kind1;
    kind_t     kind2;
    pos_e      pos0;
    pos_e      pos1;
    pos_e      pos2;
  } fmt_t;

  // One instruction as held in the input register.
  typedef struct packed {
    mnemonic_t mnemonic;
    count_t    operand_count;
    kind_t     kind_a;
    value_t    value_a;
    kind_t     kind_b;
    value_t    value_b;
    kind_t     kind_c;
    value_t    value_c;
  } insn_t;

  // One encoded result.
  typedef struct packed {
    opcode_t opcode;
    status_e status;
  } result_t;

  // Format table, searched in order; the first match wins.
  localparam fmt_t FMT_TABLE [NumFmt] = '{
    '{MN_SCD,  2'd1, 16'h00C0, K_I4,   K_NONE, K_NONE, P0, PN, PN},
    '{MN_CLS,  2'd0, 16'h00E0, K_NONE, K_NONE, K_NONE, PN, PN, PN},
    '{MN_RET,  2'd0, 16'h00EE, K_NONE, K_NONE, K_NONE, PN, PN, PN},
    '{MN_SCR,  2'd0, 16'h00FB, K_NONE, K_NONE, K_NONE, PN, PN, PN},
    '{MN_SCL,  2'd0, 16'h00FC, K_NONE, K_NONE, K_NONE, PN, PN, PN},
    '{MN_EXIT, 2'd0, 16'h00FD, K_NONE, K_NONE, K_NONE, PN, PN, PN},
    '{MN_LOW,  2'd0, 16'h00FE, K_NONE, K_NONE, K_NONE, PN, PN, PN},
    '{MN_HIGH, 2'd0, 16'h00FF, K_NONE, K_NONE, K_NONE, PN, PN, PN},
    '{MN_JP,   2'd1, 16'h1000, K_I12,  K_NONE, K_NONE, P0, PN, PN},
    '{MN_CALL, 2'd1, 16'h2000, K_I12,  K_NONE, K_NONE, P0, PN, PN},
    '{MN_SE,   2'd2, 16'h3000, K_V,    K_I8,   K_NONE, P8, P0, PN},
    '{MN_SNE,  2'd2, 16'h4000, K_V,    K_I8,   K_NONE, P8, P0, PN},
    '{MN_SE,   2'd2, 16'h5000, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_LD,   2'd2, 16'h6000, K_V,    K_I8,   K_NONE, P8, P0, PN},
    '{MN_ADD,  2'd2, 16'h7000, K_V,    K_I8,   K_NONE, P8, P0, PN},
    '{MN_LD,   2'd2, 16'h8000, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_OR,   2'd2, 16'h8001, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_AND,  2'd2, 16'h8002, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_XOR,  2'd2, 16'h8003, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_ADD,  2'd2, 16'h8004, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_SUB,  2'd2, 16'h8005, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_SHR,  2'd2, 16'h8006, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_SHR,  2'd1, 16'h8006, K_V,    K_NONE, K_NONE, P8, PN, PN},
    '{MN_SUBN, 2'd2, 16'h8007, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_SHL,  2'd2, 16'h800E, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_SHL,  2'd1, 16'h800E, K_V,    K_NONE, K_NONE, P8, PN, PN},
    '{MN_SNE,  2'd2, 16'h9000, K_V,    K_V,    K_NONE, P8, P4, PN},
    '{MN_LD,   2'd2, 16'hA000, K_I,    K_I12,  K_NONE, PN, P0, PN},
    '{MN_JPV0, 2'd1, 16'hB000, K_I12,  K_NONE, K_NONE, P0, PN, PN},
    '{MN_JP,   2'd2, 16'hB000, K_V,    K_I12,  K_NONE, PN, P0, PN},
    '{MN_RND,  2'd2, 16'hC000, K_V,    K_I8,   K_NONE, P8, P0, PN},
    '{MN_DRW,  2'd3, 16'hD000, K_V,    K_V,    K_I4,   P8, P4, P0},
    '{MN_SKP,  2'd1, 16'hE09E, K_V,    K_NONE, K_NONE, P8, PN, PN},
    '{MN_SKNP, 2'd1, 16'hE0A1, K_V,    K_NONE, K_NONE, P8, PN, PN},
    '{MN_LD,   2'd2, 16'hF007, K_V,    K_DT,   K_NONE, P8, PN, PN},
    '{MN_LD,   2'd2, 16'hF00A, K_V,    K_K,    K_NONE, P8, PN, PN},
    '{MN_LD,   2'd2, 16'hF015, K_DT,   K_V,    K_NONE, PN, P8, PN},
    '{MN_LD,   2'd2, 16'hF018, K_ST,   K_V,    K_NONE, PN, P8, PN},
    '{MN_ADD,  2'd2, 16'hF01E, K_I,    K_V,    K_NONE, PN, P8, PN},
    '{MN_LD,   2'd2, 16'hF029, K_F,    K_V,    K_NONE, PN, P8, PN},
    '{MN_LD,   2'd2, 16'hF030, K_HF,   K_V,    K_NONE, PN, P8, PN},
    '{MN_LD,   2'd2, 16'hF033, K_B,    K_V,    K_NONE, PN, P8, PN},
    '{MN_LD,   2'd2, 16'hF055, K_IP,   K_V,    K_NONE, PN, P8, PN},
    '{MN_LD,   2'd2, 16'hF065, K_V,    K_IP,   K_NONE, P8, PN, PN},
    '{MN_LD,   2'd2, 16'hF075, K_R,    K_V,    K_NONE, PN, P8, PN},
    '{MN_LD,   2'd2, 16'hF085, K_V,    K_R,    K_NONE, P8, PN, PN}
  };

endpackage

FILE: sv/c8enc_if.sv
// Valid/ready channel interfaces for instruction words and result words.
interface c8enc_req_if import c8enc_pkg::*; ();
  logic      valid;
  logic      ready;
  mnemonic_t mnemonic;
  count_t    operand_count;
  kind_t     kind_a;
  value_t    value_a;
  kind_t     kind_b;
  value_t    value_b;
  kind_t     kind_c;
  value_t    value_c;

  modport source (
    output valid, mnemonic, operand_count, kind_a, value_a, kind_b, value_b,
           kind_c, value_c,
    input  ready
  );
  modport sink (
    input  valid, mnemonic, operand_count, kind_a, value_a, kind_b, value_b,
           kind_c, value_c,
    output ready
  );
endinterface

interface c8enc_rsp_if import c8enc_pkg::*; ();
  logic             valid;
  logic             ready;
  opcode_t          opcode;
  logic [StatW-1:0] status;

  modport source (output valid, opcode, status, input ready);
  modport sink (input valid, opcode, status, output ready);
endinterface

FILE: sv/c8enc_match.sv
// Operand range check, format table search and opcode packing.
module c8enc_match import c8enc_pkg::*; (
  input  insn_t   insn_i,
  output result_t res_o
);

  kind_t  kind [NumOps];
  value_t val  [NumOps];
  logic   counted [NumOps];
  logic   range_err;
  logic   [NumFmt-1:0] hit;
  logic   found;
  logic   [FmtIdxW-1:0] idx;
  fmt_t   fmt;
  kind_t  slot [NumOps];
  pos_e   pos  [NumOps];
  opcode_t op;

  // Integer operand may fill a slot of any integer width it fits.
  function automatic logic slot_ok(kind_t k, value_t v, kind_t s);
    logic r;
    r = 1'b0;
    if (k == K_I4 || k == K_I8 || k == K_I12) begin
      case (s)
        K_I12:   r = 1'b1;
        K_I8:    r = (v[ValW-1:8] == '0);
        K_I4:    r = (v[ValW-1:4] == '0);
        default: r = 1'b0;
      endcase
    end else begin
      r = (k != K_NONE) && (k == s);
    end
    return r;
  endfunction

  // Operand shifted to its nibble place, truncated to the word.
  function automatic opcode_t place(value_t v, pos_e p);
    opcode_t r;
    r = '0;
    unique case (p)
      P0:      r = {4'd0, v};
      P4:      r = {v, 4'd0};
      P8:      r = {v[7:0], 8'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Unpack operands and flag values too large for their own kind.
  always_comb begin
    kind[0] = insn_i.kind_a;  val[0] = insn_i.value_a;
    kind[1] = insn_i.kind_b;  val[1] = insn_i.value_b;
    kind[2] = insn_i.kind_c;  val[2] = insn_i.value_c;
    range_err = 1'b0;
    for (int j = 0; j < NumOps; j++) begin
      counted[j] = (CntW'(j) < insn_i.operand_count);
      if (counted[j]) begin
        if ((kind[j] == K_V || kind[j] == K_I4) && val[j][ValW-1:4] != '0) begin
          range_err = 1'b1;
        end
        if (kind[j] == K_I8 && val[j][ValW-1:8] != '0) begin
          range_err = 1'b1;
        end
      end
    end
  end

  // Compare every table entry in parallel.
  always_comb begin
    for (int i = 0; i < NumFmt; i++) begin
      hit[i] = (FMT_TABLE[i].mn == insn_i.mnemonic) &&
               (FMT_TABLE[i].cnt == insn_i.operand_count) &&
               (!counted[0] || slot_ok(kind[0], val[0], FMT_TABLE[i].kind0)) &&
               (!counted[1] || slot_ok(kind[1], val[1], FMT_TABLE[i].kind1)) &&
               (!counted[2] || slot_ok(kind[2], val[2], FMT_TABLE[i].kind2));
    end
  end

  // The lowest matching entry wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = NumFmt - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        idx   = FmtIdxW'(i);
      end
    end
  end

  // Pack the operands into the chosen format's base word.
  always_comb begin
    fmt     = FMT_TABLE[idx];
    slot[0] = fmt.kind0;
    slot[1] = fmt.kind1;
    slot[2] = fmt.kind2;
    pos[0]  = fmt.pos0;
    pos[1]  = fmt.pos1;
    pos[2]  = fmt.pos2;
    op      = fmt.base;
    for (int j = 0; j < NumOps; j++) begin
      if (counted[j] && slot[j] != K_NONE) begin
        op = op | place(val[j], pos[j]);
      end
    end
  end

  // Range errors take priority over a missing format.
  always_comb begin
    if (range_err) begin
      res_o.opcode = '0;
      res_o.status = ST_RANGE;
    end else if (!found) begin
      res_o.opcode = '0;
      res_o.status = ST_NO_FORMAT;
    end else begin
      res_o.opcode = op;
      res_o.status = ST_OK;
    end
  end

endmodule

FILE: sv/chip8_instruction_encoder.sv
// Top level of the CHIP-8/SCHIP instruction encoder with its two register stages.
// Encodes one parsed instruction word (mnemonic, operand count and three typed
// operands) into a 16-bit opcode and a status of ok, operand too large or no
// matching format. The word is captured in an input register, matched against
// the 46-entry format table in one pass of combinational logic and written to a
// result register. One word is taken every cycle; ready drops only when the
// result register is full and not being taken while the input register also
// holds a word.
module chip8_instruction_encoder import c8enc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  c8enc_req_if.sink      req_i,
  c8enc_rsp_if.source    rsp_o
);

  logic    in_valid_q;
  insn_t   in_word_q;
  logic    out_valid_q;
  result_t out_word_q;
  result_t res;
  logic    out_free;
  logic    in_free;

  // Handshake: each stage moves on when the one after it has room.
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign in_free     = !in_valid_q || out_free;
  assign req_i.ready = in_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && req_i.valid) begin
      in_word_q <= '{
        mnemonic:      req_i.mnemonic,
        operand_count: req_i.operand_count,
        kind_a:        req_i.kind_a,
        value_a:       req_i.value_a,
        kind_b:        req_i.kind_b,
        value_b:       req_i.value_b,
        kind_c:        req_i.kind_c,
        value_c:       req_i.value_c
      };
    end
  end

  // Table match and packing.
  c8enc_match u_match (
    .insn_i (in_word_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      out_word_q <= res;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.opcode = out_word_q.opcode;
  assign rsp_o.status = out_word_q.status;

endmodule
